// File: sv/vavc_pkg.sv
// shared types and constants for the voltage average version coder
`default_nettype none

package vavc_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned IDX_W    = 3;

  // divider sizing: one quotient bit per cycle over the sum width
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned DIV_CNT_W = 5;

  // largest set size
  localparam logic [CNT_W-1:0] MAX_SAMPLES = 5'd16;

  // register reset values
  localparam logic [CNT_W-1:0]    RST_SAMPLES = 5'd1;
  localparam logic [SAMPLE_W-1:0] RST_LOW     = 16'd0;
  localparam logic [SAMPLE_W-1:0] RST_HIGH    = 16'd3300;
  localparam logic [SAMPLE_W-1:0] RST_STEP    = 16'd100;
  localparam logic [CODE_W-1:0]   RST_LOWEST  = 8'd1;
  localparam logic [CODE_W-1:0]   RST_HIGHEST = 8'd32;
  localparam logic [CODE_W-1:0]   RST_UNKNOWN = 8'd0;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_SAMPLES = 3'd0,
    CFG_LOW     = 3'd1,
    CFG_HIGH    = 3'd2,
    CFG_STEP    = 3'd3,
    CFG_LOWEST  = 3'd4,
    CFG_HIGHEST = 3'd5,
    CFG_UNKNOWN = 3'd6
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic start;
    logic sel_code;
    logic cap_avg;
    logic cap_code;
    logic push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fail;
    logic complete;
    logic div_done;
    logic need_code;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/vavc_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module vavc_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [vavc_pkg::SUM_W-1:0]    dividend_i,
  input  wire logic [vavc_pkg::SAMPLE_W-1:0] divisor_i,
  output logic                              done_o,
  output logic [vavc_pkg::SUM_W-1:0]         quotient_o
);

  logic [vavc_pkg::SUM_W-1:0]     dvd_q, dvd_d;
  logic [vavc_pkg::SAMPLE_W-1:0]  dvs_q;
  logic [vavc_pkg::SAMPLE_W-1:0]  rem_q, rem_d;
  logic [vavc_pkg::SAMPLE_W:0]    shifted;
  logic [vavc_pkg::SAMPLE_W:0]    trial;
  logic                           qbit;
  logic [vavc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  // one restoring step
  always_comb begin
    shifted = {rem_q, dvd_q[vavc_pkg::SUM_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    qbit    = (shifted >= {1'b0, dvs_q});
    rem_d   = qbit ? trial[vavc_pkg::SAMPLE_W-1:0] : shifted[vavc_pkg::SAMPLE_W-1:0];
    dvd_d   = {dvd_q[vavc_pkg::SUM_W-2:0], qbit};
  end

  // control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= vavc_pkg::DIV_CNT_W'(vavc_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - vavc_pkg::DIV_CNT_W'(1);
        if (cnt_q == vavc_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire

// File: sv/vavc_dp.sv
// datapath: configuration, sample accumulation, code mapping, output word
`default_nettype none

module vavc_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [vavc_pkg::IDX_W-1:0]     cfg_idx_i,
  input  wire logic [vavc_pkg::SAMPLE_W-1:0]  cfg_wdata_i,
  input  wire logic [vavc_pkg::SAMPLE_W-1:0]  sample_mv_i,
  input  wire logic                          read_failed_i,
  input  wire logic                          restart_i,
  input  wire vavc_pkg::cmd_t                cmd_i,
  output vavc_pkg::sts_t                     sts_o,
  output logic [vavc_pkg::CODE_W-1:0]         version_code_o,
  output logic                               code_valid_o,
  output logic                               status_o,
  output logic [vavc_pkg::SAMPLE_W-1:0]       average_mv_o
);

  // configuration registers
  logic [vavc_pkg::CNT_W-1:0]    samples_q;
  logic [vavc_pkg::SAMPLE_W-1:0] low_q, high_q, step_q;
  logic [vavc_pkg::CODE_W-1:0]   lowest_q, highest_q, unknown_q;

  // accumulation state
  logic [vavc_pkg::SUM_W-1:0]    sum_q;
  logic [vavc_pkg::CNT_W-1:0]    cnt_q;
  logic [vavc_pkg::SUM_W-1:0]    set_sum_q;
  logic [vavc_pkg::CNT_W-1:0]    set_cnt_q;
  logic [vavc_pkg::SAMPLE_W-1:0] avg_q;

  // pending result and output word
  logic [vavc_pkg::CODE_W-1:0]   pend_code_q;
  logic                          pend_valid_q;
  logic                          pend_status_q;
  logic [vavc_pkg::SAMPLE_W-1:0] pend_avg_q;
  logic [vavc_pkg::CODE_W-1:0]   out_code_q;
  logic                          out_valid_q;
  logic                          out_status_q;
  logic [vavc_pkg::SAMPLE_W-1:0] out_avg_q;

  logic [vavc_pkg::SUM_W-1:0]    base_sum, new_sum;
  logic [vavc_pkg::CNT_W-1:0]    base_cnt, new_cnt, eff_cnt;
  logic                          complete;
  logic [vavc_pkg::SUM_W-1:0]    div_dividend;
  logic [vavc_pkg::SAMPLE_W-1:0] div_divisor, step_eff;
  logic                          div_done;
  logic [vavc_pkg::SUM_W-1:0]    quot;
  logic [vavc_pkg::SAMPLE_W-1:0] quot_avg;
  logic                          at_low, at_high;
  logic [vavc_pkg::SAMPLE_W:0]   raw_code, lo_code, clamp_code;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= vavc_pkg::RST_SAMPLES;
      low_q     <= vavc_pkg::RST_LOW;
      high_q    <= vavc_pkg::RST_HIGH;
      step_q    <= vavc_pkg::RST_STEP;
      lowest_q  <= vavc_pkg::RST_LOWEST;
      highest_q <= vavc_pkg::RST_HIGHEST;
      unknown_q <= vavc_pkg::RST_UNKNOWN;
    end else if (cfg_we_i) begin
      unique case (vavc_pkg::cfg_idx_e'(cfg_idx_i))
        vavc_pkg::CFG_SAMPLES: samples_q <= cfg_wdata_i[vavc_pkg::CNT_W-1:0];
        vavc_pkg::CFG_LOW:     low_q     <= cfg_wdata_i;
        vavc_pkg::CFG_HIGH:    high_q    <= cfg_wdata_i;
        vavc_pkg::CFG_STEP:    step_q    <= cfg_wdata_i;
        vavc_pkg::CFG_LOWEST:  lowest_q  <= cfg_wdata_i[vavc_pkg::CODE_W-1:0];
        vavc_pkg::CFG_HIGHEST: highest_q <= cfg_wdata_i[vavc_pkg::CODE_W-1:0];
        vavc_pkg::CFG_UNKNOWN: unknown_q <= cfg_wdata_i[vavc_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // set size: zero counts as one, capped at the maximum
  always_comb begin
    eff_cnt = samples_q;
    if (samples_q == '0) begin
      eff_cnt = vavc_pkg::CNT_W'(1);
    end else if (samples_q > vavc_pkg::MAX_SAMPLES) begin
      eff_cnt = vavc_pkg::MAX_SAMPLES;
    end
  end

  // sum with this sample, restart dropping the partial set first
  always_comb begin
    base_sum = restart_i ? '0 : sum_q;
    base_cnt = restart_i ? '0 : cnt_q;
    new_sum  = base_sum + vavc_pkg::SUM_W'(sample_mv_i);
    new_cnt  = base_cnt + vavc_pkg::CNT_W'(1);
    complete = !read_failed_i && (new_cnt >= eff_cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.accept) begin
      if (read_failed_i || complete) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= new_sum;
        cnt_q <= new_cnt;
      end
    end
  end

  // shared divider: sum by count, then average by step
  assign step_eff     = (step_q == '0) ? vavc_pkg::SAMPLE_W'(1) : step_q;
  assign div_dividend = cmd_i.sel_code ? vavc_pkg::SUM_W'(avg_q) : set_sum_q;
  assign div_divisor  = cmd_i.sel_code ? step_eff : vavc_pkg::SAMPLE_W'(set_cnt_q);

  vavc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // limit tests on the average and clamped code from the step quotient
  always_comb begin
    quot_avg   = quot[vavc_pkg::SAMPLE_W-1:0];
    at_low     = (quot_avg <= low_q);
    at_high    = (quot_avg >= high_q);
    raw_code   = {1'b0, quot[vavc_pkg::SAMPLE_W-1:0]} + (vavc_pkg::SAMPLE_W + 1)'(1);
    lo_code    = (raw_code < (vavc_pkg::SAMPLE_W + 1)'(lowest_q))
                 ? (vavc_pkg::SAMPLE_W + 1)'(lowest_q) : raw_code;
    clamp_code = (lo_code > (vavc_pkg::SAMPLE_W + 1)'(highest_q))
                 ? (vavc_pkg::SAMPLE_W + 1)'(highest_q) : lo_code;
  end

  // set capture and pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && complete) begin
      set_sum_q <= new_sum;
      set_cnt_q <= new_cnt;
    end
    if (cmd_i.accept && read_failed_i) begin
      pend_code_q   <= unknown_q;
      pend_valid_q  <= 1'b0;
      pend_status_q <= 1'b1;
      pend_avg_q    <= '0;
    end
    if (cmd_i.cap_avg) begin
      avg_q         <= quot_avg;
      pend_avg_q    <= quot_avg;
      pend_valid_q  <= 1'b1;
      pend_status_q <= 1'b0;
      if (at_low) begin
        pend_code_q <= lowest_q;
      end else if (at_high) begin
        pend_code_q <= highest_q;
      end
    end
    if (cmd_i.cap_code) begin
      pend_code_q <= clamp_code[vavc_pkg::CODE_W-1:0];
    end
    if (cmd_i.push) begin
      out_code_q   <= pend_code_q;
      out_valid_q  <= pend_valid_q;
      out_status_q <= pend_status_q;
      out_avg_q    <= pend_avg_q;
    end
  end

  assign sts_o.fail      = read_failed_i;
  assign sts_o.complete  = complete;
  assign sts_o.div_done  = div_done;
  assign sts_o.need_code = !at_low && !at_high;

  assign version_code_o = out_code_q;
  assign code_valid_o   = out_valid_q;
  assign status_o       = out_status_q;
  assign average_mv_o   = out_avg_q;

endmodule

`default_nettype wire

// File: sv/vavc_ctrl.sv
// controller: input acceptance, divider sequencing, output word valid
`default_nettype none

module vavc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire vavc_pkg::sts_t sts_i,
  output vavc_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AVG,
    ST_CODE,
    ST_PUSH
  } state_e;

  state_e state_q, state_d;
  logic   start_q, start_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  // commands
  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    accept         = in_valid_i && in_ready_o;
    slot_free      = !out_valid_q || out_ready_i;
    cmd_o.accept   = accept;
    cmd_o.start    = start_q;
    cmd_o.sel_code = (state_q == ST_CODE);
    cmd_o.cap_avg  = (state_q == ST_AVG) && sts_i.div_done;
    cmd_o.cap_code = (state_q == ST_CODE) && sts_i.div_done;
    cmd_o.push     = (state_q == ST_PUSH) && slot_free;
  end

  // next state
  always_comb begin
    state_d = state_q;
    start_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.fail) begin
          state_d = ST_PUSH;
        end else if (accept && sts_i.complete) begin
          state_d = ST_AVG;
          start_d = 1'b1;
        end
      end
      ST_AVG: begin
        if (sts_i.div_done) begin
          if (sts_i.need_code) begin
            state_d = ST_CODE;
            start_d = 1'b1;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_CODE: begin
        if (sts_i.div_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = cmd_o.push ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: sv/voltage_average_version_coder_unit.sv
// top level: averages sample sets and maps the average to a version code
// a sample that does not finish a set only updates the running sum; a failed
//   read goes to the push state and then to the output word; a finished set
//   runs the divider for the average, and again when it lies between the limits
// throughput: one word at a time, bounded by the 20-step shared divider
// reset: asynchronous, active low; registers return to their reset values
//   and the partial set and output valid are cleared
`default_nettype none

module voltage_average_version_coder_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [vavc_pkg::IDX_W-1:0]     cfg_idx_i,
  input  wire logic [vavc_pkg::SAMPLE_W-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [vavc_pkg::SAMPLE_W-1:0]  sample_mv_i,
  input  wire logic                          read_failed_i,
  input  wire logic                          restart_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [vavc_pkg::CODE_W-1:0]         version_code_o,
  output logic                               code_valid_o,
  output logic                               status_o,
  output logic [vavc_pkg::SAMPLE_W-1:0]       average_mv_o
);

  vavc_pkg::cmd_t cmd;
  vavc_pkg::sts_t sts;

  // sequencing
  vavc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic and registers
  vavc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_mv_i    (sample_mv_i),
    .read_failed_i  (read_failed_i),
    .restart_i      (restart_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .version_code_o (version_code_o),
    .code_valid_o   (code_valid_o),
    .status_o       (status_o),
    .average_mv_o   (average_mv_o)
  );

endmodule

`default_nettype wire

// File: sv/vavc_checker.sv
// port-level checks for the version coder, bound to the top level
`default_nettype none

module vavc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          read_failed_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [vavc_pkg::CODE_W-1:0]    version_code_o,
  input wire logic                          code_valid_o,
  input wire logic                          status_o,
  input wire logic [vavc_pkg::SAMPLE_W-1:0]  average_mv_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(version_code_o))
    else $error("output word changed while stalled");

  // a failure word carries no detection and a zero average
  a_fail_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !code_valid_o && (average_mv_o == '0))
    else $error("failure word with detection fields");

  // a detection word is marked valid
  a_good_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |-> code_valid_o)
    else $error("detection word not marked valid");

  // a failed read blocks input until its word is queued
  a_fail_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && read_failed_i |=> !in_ready_o)
    else $error("input taken while a failure word is pending");

endmodule

bind voltage_average_version_coder_unit vavc_checker u_vavc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .read_failed_i  (read_failed_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .version_code_o (version_code_o),
  .code_valid_o   (code_valid_o),
  .status_o       (status_o),
  .average_mv_o   (average_mv_o)
);

`default_nettype wire
